// ===== rtl/core/brt_pkg.sv =====
// Shared types and constants for the build-rule tokenizer.
// No dependencies; imported by every module of the block.
package brt_pkg;

    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;

    localparam logic [2:0] KIND_LIT   = 3'd0;
    localparam logic [2:0] KIND_VAR   = 3'd1;
    localparam logic [2:0] KIND_COLON = 3'd2;
    localparam logic [2:0] KIND_NL    = 3'd3;
    localparam logic [2:0] KIND_ERR   = 3'd4;

    // Result queue: 2**FIFO_AW entries
    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_LIT    = 3'd1,
        MODE_VAR    = 3'd2,
        MODE_DOLLAR = 3'd3,
        MODE_ERR    = 3'd4
    } brt_mode_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       char_valid;
        logic [7:0] ch;
        logic       token_end;
        logic       run_last;
    } brt_result_t;

    typedef struct packed {
        logic has_data;
        logic room_two;
    } brt_fifo_stat_t;

endpackage

// ===== rtl/core/brt_decode.sv =====
// Per-byte decode: classify one byte against the scan mode, produce up to
// two result beats and the next mode. Depends on brt_pkg.
module brt_decode (
    input  brt_pkg::brt_mode_t         mode,
    input  logic [7:0]                 text_byte,
    input  logic                       end_of_text,
    output brt_pkg::brt_result_t [1:0] res,
    output logic [1:0]                 res_count,
    output brt_pkg::brt_mode_t         mode_next
);
    import brt_pkg::*;

    function automatic brt_result_t mk(input logic [2:0] kind, input logic valid,
                                       input logic [7:0] ch, input logic tend);
        brt_result_t r;
        r.kind       = kind;
        r.char_valid = valid;
        r.ch         = valid ? ch : 8'h00;
        r.token_end  = tend;
        r.run_last   = 1'b0;
        return r;
    endfunction

    logic is_ws;
    logic is_letter;
    logic is_alnum;

    assign is_ws     = (text_byte == 8'h20) || (text_byte >= 8'h09 && text_byte <= 8'h0D);
    assign is_letter = (text_byte >= 8'h41 && text_byte <= 8'h5A)
                    || (text_byte >= 8'h61 && text_byte <= 8'h7A);
    assign is_alnum  = is_letter || (text_byte >= 8'h30 && text_byte <= 8'h39);

    always_comb
    begin
        logic       start_new;
        logic [1:0] cnt;
        start_new = 1'b0;
        cnt       = 2'd0;
        res       = '0;
        mode_next = mode;

        case (mode)
            MODE_IDLE:
            begin
                start_new = 1'b1;
            end
            MODE_LIT:
            begin
                if (is_ws || text_byte == CHAR_COLON)
                begin
                    res[cnt[0]] = mk(KIND_LIT, 1'b0, 8'h00, 1'b1);
                    cnt         = cnt + 2'd1;
                    mode_next   = MODE_IDLE;
                    start_new   = 1'b1;
                end
                else
                begin
                    res[cnt[0]] = mk(KIND_LIT, 1'b1, text_byte, end_of_text);
                    cnt         = cnt + 2'd1;
                end
            end
            MODE_VAR:
            begin
                if (is_alnum)
                begin
                    res[cnt[0]] = mk(KIND_VAR, 1'b1, text_byte, end_of_text);
                    cnt         = cnt + 2'd1;
                end
                else
                begin
                    res[cnt[0]] = mk(KIND_VAR, 1'b0, 8'h00, 1'b1);
                    cnt         = cnt + 2'd1;
                    mode_next   = MODE_IDLE;
                    start_new   = 1'b1;
                end
            end
            MODE_DOLLAR:
            begin
                if (is_letter)
                begin
                    res[0]    = mk(KIND_VAR, 1'b1, CHAR_DOLLAR, 1'b0);
                    res[1]    = mk(KIND_VAR, 1'b1, text_byte, end_of_text);
                    cnt       = 2'd2;
                    mode_next = MODE_VAR;
                end
                else
                begin
                    res[0]    = mk(KIND_ERR, 1'b0, 8'h00, 1'b1);
                    cnt       = 2'd1;
                    mode_next = MODE_ERR;
                end
            end
            default:
            begin
                // error mode and unused codes: drop the byte
            end
        endcase

        if (start_new)
        begin
            if (text_byte == CHAR_NL)
            begin
                res[cnt[0]] = mk(KIND_NL, 1'b1, text_byte, 1'b1);
                cnt         = cnt + 2'd1;
            end
            else if (is_ws)
            begin
                // skip whitespace between tokens
            end
            else if (text_byte == CHAR_COLON)
            begin
                res[cnt[0]] = mk(KIND_COLON, 1'b1, text_byte, 1'b1);
                cnt         = cnt + 2'd1;
            end
            else if (text_byte == CHAR_DOLLAR)
            begin
                if (end_of_text)
                begin
                    res[cnt[0]] = mk(KIND_ERR, 1'b0, 8'h00, 1'b1);
                    cnt         = cnt + 2'd1;
                end
                else
                begin
                    mode_next = MODE_DOLLAR;
                end
            end
            else
            begin
                res[cnt[0]] = mk(KIND_LIT, 1'b1, text_byte, end_of_text);
                cnt         = cnt + 2'd1;
                mode_next   = MODE_LIT;
            end
        end

        if (end_of_text)
        begin
            mode_next = MODE_IDLE;
        end

        if (cnt == 2'd2)
        begin
            res[1].run_last = 1'b1;
        end
        else if (cnt == 2'd1)
        begin
            res[0].run_last = 1'b1;
        end
        res_count = cnt;
    end

endmodule

// ===== rtl/core/brt_result_fifo.sv =====
// Result queue: takes zero, one or two result beats per cycle, hands out
// one per cycle while popped. Depends on brt_pkg.
module brt_result_fifo (
    input  logic                       clk,
    input  logic                       rst_n,
    input  brt_pkg::brt_result_t [1:0] push_data,
    input  logic [1:0]                 push_count,
    input  logic                       pop,
    output brt_pkg::brt_result_t       head,
    output brt_pkg::brt_fifo_stat_t    stat
);
    import brt_pkg::*;

    localparam logic [FIFO_AW:0] ROOM_LIMIT = (FIFO_AW + 1)'(FIFO_DEPTH - 2);

    brt_result_t          mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;
    logic [FIFO_AW-1:0]   wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_next;
    logic [FIFO_AW:0]     count_next;
    logic                 do_pop;

    assign do_pop        = pop && (count_reg != '0);
    assign wr_ptr_next   = wr_ptr_reg + FIFO_AW'(push_count);
    assign rd_ptr_next   = rd_ptr_reg + FIFO_AW'(do_pop);
    assign count_next    = count_reg + (FIFO_AW + 1)'(push_count) - (FIFO_AW + 1)'(do_pop);
    assign head          = mem[rd_ptr_reg];
    assign stat.has_data = (count_reg != '0);
    assign stat.room_two = (count_reg <= ROOM_LIMIT);

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_data[0];
        end
        if (push_count == 2'd2)
        begin
            mem[wr_ptr_reg + FIFO_AW'(1)] <= push_data[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("result queue count above depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push_count != 2'd0) |-> (count_reg + (FIFO_AW + 1)'(push_count)
                                  <= (FIFO_AW + 1)'(FIFO_DEPTH)))
        else $error("result queue overflow");

    a_push_code: assert property (@(posedge clk) disable iff (!rst_n)
        push_count != 2'd3)
        else $error("more than two results pushed");

endmodule

// ===== rtl/core/build_rule_tokenizer_core.sv =====
// Build-rule tokenizer top level: input register, scan mode, decode and
// result queue. Depends on brt_pkg, brt_decode, brt_result_fifo.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------------
//  input   | in        | in_valid / in_ready   | text_byte, end_of_text
//  output  | out       | out_valid / out_ready | token_kind, char_valid, out_char,
//          |           |                       | token_end, run_last
//
// One text byte enters per cycle while in_ready is high. A byte reaches the
// input register on its beat, is decoded against the scan mode once the queue
// can take two beats and leaves 0..2 result beats in a 4-entry queue, whose
// head is presented on the output until taken.
// Sustained rate is one byte per cycle while results
// are taken, bounded by the output port's one result beat per cycle.
// in_ready drops only while the input register holds a byte and the queue
// has fewer than two free entries. Reset clears the mode to idle and
// empties the input register and the queue.
module build_rule_tokenizer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] token_kind,
    output logic       char_valid,
    output logic [7:0] out_char,
    output logic       token_end,
    output logic       run_last
);
    import brt_pkg::*;

    // Input register: one byte beat waiting for decode
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_eot_reg;

    brt_mode_t        mode_reg;
    brt_mode_t        mode_next;

    brt_result_t [1:0] dec_res;
    logic [1:0]        dec_count;
    brt_result_t       head;
    brt_fifo_stat_t    qstat;

    logic             consume;
    logic [1:0]       push_count;

    // Decode the held byte only when the queue can take two beats
    assign consume    = in_valid_reg && qstat.room_two;
    assign in_ready   = !in_valid_reg || consume;
    assign push_count = consume ? dec_count : 2'd0;

    brt_decode u_decode (
        .mode        (mode_reg),
        .text_byte   (in_byte_reg),
        .end_of_text (in_eot_reg),
        .res         (dec_res),
        .res_count   (dec_count),
        .mode_next   (mode_next)
    );

    brt_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (dec_res),
        .push_count (push_count),
        .pop        (out_ready),
        .head       (head),
        .stat       (qstat)
    );

    // Present the queue head; it holds until popped
    assign out_valid  = qstat.has_data;
    assign token_kind = head.kind;
    assign char_valid = head.char_valid;
    assign out_char   = head.ch;
    assign token_end  = head.token_end;
    assign run_last   = head.run_last;

    // Payload of the input register: load on each input beat
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= text_byte;
            in_eot_reg  <= end_of_text;
        end
    end

    // Control: input register occupancy and scan mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_IDLE;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (consume)
            begin
                in_valid_reg <= 1'b0;
            end
            if (consume)
            begin
                mode_reg <= mode_next;
            end
        end
    end

    a_eot_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && in_eot_reg) |=> (mode_reg == MODE_IDLE))
        else $error("mode not idle after end of text");

    a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !consume |=> $stable(mode_reg))
        else $error("mode changed without a decoded byte");

    a_two_needs_dollar: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && dec_count == 2'd2) |-> (mode_reg != MODE_IDLE))
        else $error("two results from a byte decoded in idle mode");

endmodule
